>>> rtl/core/bswr_pkg.sv
// Shared types and constants for the bounded stack with reverse.
// Holds the request and response payloads, operation and status codes, and
// the command and status groups between the controller and the datapath.
`default_nettype none

package bswr_pkg;

   localparam int VALUE_W  = 8;
   localparam int POS_W    = 7;
   localparam int OP_W     = 3;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;

   // Operation codes carried in the request.
   localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
   localparam logic [OP_W-1:0] OP_POP     = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
   localparam logic [OP_W-1:0] OP_READ    = 3'd3;
   localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

   // Status codes returned with every response.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] push_value;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic exec;
      logic rev_read;
      logic rev_write_lo;
      logic rev_write_hi;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_reverse;
      logic rev_more;
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/core/bswr_ctrl.sv
// Controller state machine for the bounded stack with reverse.
// Sequences request capture, execution, the reverse swap loop and the response.
// Depends on bswr_pkg for the command and status groups.
`default_nettype none

module bswr_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   output logic                rsp_valid,
   input  bswr_pkg::stat_type  stat,
   output bswr_pkg::cmd_type   cmd
);

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_EXEC      = 6'b000010,
      S_RESP      = 6'b000100,
      S_REV_CHECK = 6'b001000,
      S_REV_WLO   = 6'b010000,
      S_REV_WHI   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.is_reverse ? S_REV_CHECK : S_RESP;
         end
         S_REV_CHECK: begin
            if (stat.rev_more) begin
               cmd.rev_read = 1'b1;
               state_in     = S_REV_WLO;
            end else begin
               state_in = S_RESP;
            end
         end
         S_REV_WLO: begin
            cmd.rev_write_lo = 1'b1;
            state_in         = S_REV_WHI;
         end
         S_REV_WHI: begin
            cmd.rev_write_hi = 1'b1;
            state_in         = S_REV_CHECK;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

`default_nettype wire

>>> rtl/core/bswr_datapath.sv
// Datapath for the bounded stack with reverse: element store, count,
// swap pointers and response registers. Driven by commands from bswr_ctrl.
// Depends on bswr_pkg for payload types, codes and command groups.
`default_nettype none

module bswr_datapath #(
   parameter int DEPTH = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  bswr_pkg::req_type   req_in,
   input  bswr_pkg::cmd_type   cmd,
   output bswr_pkg::stat_type  stat,
   output bswr_pkg::rsp_type   rsp
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > bswr_pkg::POS_W) ? CW : bswr_pkg::POS_W;

   logic [bswr_pkg::VALUE_W-1:0] mem [DEPTH];

   bswr_pkg::req_type req_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [bswr_pkg::STATUS_W-1:0] status_ff, status_in;
   logic rd_ok_ff, rd_ok_in;
   logic [bswr_pkg::VALUE_W-1:0] q_a_ff, q_b_ff;

   logic                         we;
   logic [AW-1:0]                waddr;
   logic [bswr_pkg::VALUE_W-1:0] wdata;
   logic                         re_a, re_b;
   logic [AW-1:0]                raddr_a;

   logic            full, empty, pos_ok;
   logic [CW-1:0]   cnt_m1, hi_m1;
   logic [CMPW-1:0] pos_ext, cnt_ext, pos_m1;

   // Bounds and derived addresses.
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign cnt_m1  = count_ff - CW'(1);
   assign hi_m1   = hi_ff - CW'(1);
   assign pos_ext = CMPW'(req_ff.position);
   assign cnt_ext = CMPW'(count_ff);
   assign pos_m1  = pos_ext - CMPW'(1);
   assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

   // Operation decode and the reverse swap sequence.
   always_comb begin
      count_in  = count_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      status_in = status_ff;
      rd_ok_in  = rd_ok_ff;
      we        = 1'b0;
      waddr     = count_ff[AW-1:0];
      wdata     = req_ff.push_value;
      re_a      = 1'b0;
      re_b      = 1'b0;
      raddr_a   = cnt_m1[AW-1:0];

      if (cmd.exec) begin
         status_in = bswr_pkg::ST_OK;
         rd_ok_in  = 1'b0;
         unique case (req_ff.op)
            bswr_pkg::OP_PUSH: begin
               if (full) begin
                  status_in = bswr_pkg::ST_OVERFLOW;
               end else begin
                  we       = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            bswr_pkg::OP_POP: begin
               if (empty) begin
                  status_in = bswr_pkg::ST_UNDERFLOW;
               end else begin
                  re_a     = 1'b1;
                  rd_ok_in = 1'b1;
                  count_in = cnt_m1;
               end
            end
            bswr_pkg::OP_PEEK: begin
               if (empty) begin
                  status_in = bswr_pkg::ST_UNDERFLOW;
               end else begin
                  re_a     = 1'b1;
                  rd_ok_in = 1'b1;
               end
            end
            bswr_pkg::OP_READ: begin
               if (!pos_ok) begin
                  status_in = bswr_pkg::ST_RANGE;
               end else begin
                  re_a     = 1'b1;
                  raddr_a  = pos_m1[AW-1:0];
                  rd_ok_in = 1'b1;
               end
            end
            bswr_pkg::OP_REVERSE: begin
               lo_in = '0;
               hi_in = count_ff;
            end
            bswr_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      // Fetch both ends of the remaining span.
      if (cmd.rev_read) begin
         re_a    = 1'b1;
         re_b    = 1'b1;
         raddr_a = lo_ff[AW-1:0];
      end

      // The upper element goes to the low slot first.
      if (cmd.rev_write_lo) begin
         we    = 1'b1;
         waddr = lo_ff[AW-1:0];
         wdata = q_b_ff;
      end

      // Then the lower element goes to the high slot and the span shrinks.
      if (cmd.rev_write_hi) begin
         we    = 1'b1;
         waddr = hi_m1[AW-1:0];
         wdata = q_a_ff;
         lo_in = lo_ff + CW'(1);
         hi_in = hi_m1;
      end
   end

   // Element store with registered reads.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re_a) begin
         q_a_ff <= mem[raddr_a];
      end
      if (re_b) begin
         q_b_ff <= mem[hi_m1[AW-1:0]];
      end
   end

   // Request capture and working registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.is_reverse = (req_ff.op == bswr_pkg::OP_REVERSE);
   assign stat.rev_more   = (hi_ff > (lo_ff + CW'(1)));

   // Response fields.
   assign rsp.read_value = rd_ok_ff ? q_a_ff : '0;
   assign rsp.count      = bswr_pkg::COUNT_W'(count_ff);
   assign rsp.is_empty   = empty;
   assign rsp.status     = status_ff;

endmodule

`default_nettype wire

>>> rtl/core/bounded_stack_with_reverse.sv
// Bounded LIFO stack of bytes with push, pop, peek, positional read, reverse, clear.
// Sequence: an accepted request passes through an execute state to the response state;
// a reverse of n elements first runs floor(n/2) swaps, one per pass through the check,
// low-write and high-write states.
// A new request is taken only when the block is idle again, after its response.
// Reset clears the element count; the store holds no reset value, and the receiver
// cannot stall: each response is shown for one cycle only.
`default_nettype none

module bounded_stack_with_reverse #(
   parameter int DEPTH = 64
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  bswr_pkg::req_type  req_data,
   output logic               rsp_valid,
   output bswr_pkg::rsp_type  rsp_data
);

   bswr_pkg::cmd_type  cmd;
   bswr_pkg::stat_type stat;

   // Controller.
   bswr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath.
   bswr_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_in (req_data),
      .cmd    (cmd),
      .stat   (stat),
      .rsp    (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/core/bswr_checker.sv
// Port-level checks for the bounded stack with reverse, bound to the top level.
// Depends on bswr_pkg for payload types and status codes.
`default_nettype none

module bswr_checker (
   input wire                clock,
   input wire                reset,
   input wire                start,
   input wire                busy,
   input wire                rsp_valid,
   input bswr_pkg::rsp_type  rsp_data
);

   // An accepted transfer makes the block busy at once.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an accepted request");

   // A response only appears while a request is in flight.
   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   // The strobe lasts exactly one cycle and the block then goes idle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response strobe longer than one cycle");

   // Any failed request returns no data.
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != bswr_pkg::ST_OK)) |-> (rsp_data.read_value == '0))
      else $error("read value nonzero on an error response");

   // Underflow only happens on an empty stack.
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == bswr_pkg::ST_UNDERFLOW)) |-> rsp_data.is_empty)
      else $error("underflow reported on a non-empty stack");

endmodule

bind bounded_stack_with_reverse bswr_checker u_bswr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/sv/bounded_stack_with_reverse_test.sv
// Self-checking testbench for the bounded stack with reverse.
// Drives push, pop, peek, positional read, reverse and clear requests, and checks
// every response against a scoreboard that tracks the stack. Uses only bswr_pkg.
`timescale 1ns / 1ps

module bounded_stack_with_reverse_test;

   localparam int STACK_DEPTH    = 64;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = 120;

   // Opcodes the block does not define; they must be answered and otherwise ignored.
   localparam logic [bswr_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [bswr_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

   typedef enum int {MIX_BALANCED, MIX_PUSH, MIX_POP, MIX_FILL} mix_type;

   // Tracks the stack contents and holds the responses still to come.
   class stack_scoreboard;
      logic [bswr_pkg::VALUE_W-1:0] elems [STACK_DEPTH];
      int unsigned                  depth_used;
      int unsigned                  deepest;
      int unsigned                  wide_reverses;
      int unsigned                  errors;
      int unsigned                  checked;
      int unsigned                  status_seen [4];
      bswr_pkg::rsp_type            pending [$];

      // Work out the response to one accepted request and queue it.
      function void note_request(bswr_pkg::req_type r);
         bswr_pkg::rsp_type            e;
         int unsigned                  lo;
         int unsigned                  hi;
         logic [bswr_pkg::VALUE_W-1:0] t;
         e = '0;
         case (r.op)
            bswr_pkg::OP_PUSH: begin
               if (depth_used >= STACK_DEPTH) begin
                  e.status = bswr_pkg::ST_OVERFLOW;
               end else begin
                  elems[depth_used] = r.push_value;
                  depth_used++;
               end
            end
            bswr_pkg::OP_POP: begin
               if (depth_used == 0) begin
                  e.status = bswr_pkg::ST_UNDERFLOW;
               end else begin
                  depth_used--;
                  e.read_value = elems[depth_used];
               end
            end
            bswr_pkg::OP_PEEK: begin
               if (depth_used == 0) e.status = bswr_pkg::ST_UNDERFLOW;
               else e.read_value = elems[depth_used - 1];
            end
            bswr_pkg::OP_READ: begin
               if (r.position == 0 || r.position > depth_used) e.status = bswr_pkg::ST_RANGE;
               else e.read_value = elems[r.position - 1];
            end
            bswr_pkg::OP_REVERSE: begin
               if (depth_used > 1) wide_reverses++;
               lo = 0;
               hi = depth_used;
               while (hi > lo + 1) begin
                  hi--;
                  t         = elems[lo];
                  elems[lo] = elems[hi];
                  elems[hi] = t;
                  lo++;
               end
            end
            bswr_pkg::OP_CLEAR: depth_used = 0;
            default: ;
         endcase
         if (depth_used > deepest) deepest = depth_used;
         e.count    = bswr_pkg::COUNT_W'(depth_used);
         e.is_empty = (depth_used == 0);
         pending.push_back(e);
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         errors++;
      endtask

      // Compare one response with the oldest expectation, field by field.
      task check_response(bswr_pkg::rsp_type got);
         bswr_pkg::rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("response %p arrived with nothing outstanding", got));
         end else begin
            e = pending.pop_front();
            checked++;
            status_seen[e.status]++;
            if (got.read_value !== e.read_value)
               report($sformatf("read_value %0h, expected %0h", got.read_value, e.read_value));
            if (got.count !== e.count)
               report($sformatf("count %0d, expected %0d", got.count, e.count));
            if (got.is_empty !== e.is_empty)
               report($sformatf("is_empty %b, expected %b", got.is_empty, e.is_empty));
            if (got.status !== e.status)
               report($sformatf("status %0d, expected %0d", got.status, e.status));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   bswr_pkg::req_type req_data;
   logic              rsp_valid;
   bswr_pkg::rsp_type rsp_data;

   stack_scoreboard sb;
   mix_type         mix;
   bit              no_gap_phase;
   int unsigned     idle_cycles;
   int unsigned     sent;

   bounded_stack_with_reverse dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Every strobed response is checked on the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transfer in %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic bswr_pkg::req_type make_req(logic [bswr_pkg::OP_W-1:0] op,
                                                  logic [bswr_pkg::VALUE_W-1:0] val,
                                                  logic [bswr_pkg::POS_W-1:0] pos);
      bswr_pkg::req_type r;
      r.op         = op;
      r.push_value = val;
      r.position   = pos;
      return r;
   endfunction

   // Mostly short gaps, a few long ones, none at all during some phases.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gap_phase || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random request whose operation mix depends on the current phase.
   function automatic bswr_pkg::req_type random_req();
      bswr_pkg::req_type r;
      int unsigned       push_pct;
      int unsigned       pop_pct;
      int unsigned       roll;
      int unsigned       held;
      held = sb.depth_used;
      case (mix)
         MIX_PUSH: begin push_pct = 65; pop_pct = 10; end
         MIX_POP:  begin push_pct = 15; pop_pct = 55; end
         MIX_FILL: begin push_pct = 90; pop_pct = 3;  end
         default:  begin push_pct = 40; pop_pct = 25; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
         r.op = bswr_pkg::OP_PUSH;
      end else if (roll < push_pct + pop_pct) begin
         r.op = bswr_pkg::OP_POP;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 25)      r.op = bswr_pkg::OP_PEEK;
         else if (roll < 65) r.op = bswr_pkg::OP_READ;
         else if (roll < 85) r.op = bswr_pkg::OP_REVERSE;
         else if (roll < 93) r.op = bswr_pkg::OP_CLEAR;
         else if (roll < 97) r.op = OP_SPARE_6;
         else                r.op = OP_SPARE_7;
      end
      roll = $urandom_range(0, 9);
      if (roll == 0)      r.push_value = '0;
      else if (roll == 1) r.push_value = '1;
      else                r.push_value = bswr_pkg::VALUE_W'($urandom_range(0, 255));
      roll = $urandom_range(0, 9);
      if (roll == 0)      r.position = '0;
      else if (roll == 1) r.position = bswr_pkg::POS_W'($urandom_range(0, 127));
      else if (roll == 2) r.position = bswr_pkg::POS_W'(held + 1);
      else r.position = bswr_pkg::POS_W'($urandom_range(1, (held > 0) ? held : 1));
      return r;
   endfunction

   // One request transfer, then the idle gap that follows it.
   task automatic send_request(bswr_pkg::req_type r);
      int unsigned gap;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   initial begin
      bswr_pkg::req_type directed [$];
      int unsigned       phase_left;
      sb           = new();
      mix          = MIX_BALANCED;
      no_gap_phase = 1'b0;
      sent         = 0;
      idle_cycles  = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty-stack errors, field extremes, small reverses, spare opcodes.
      directed.push_back(make_req(bswr_pkg::OP_POP,     8'h00, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_PEEK,    8'hFF, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_READ,    8'h00, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_READ,    8'h00, 7'd1));
      directed.push_back(make_req(bswr_pkg::OP_REVERSE, 8'h00, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_PUSH,    8'h00, 7'd127));
      directed.push_back(make_req(bswr_pkg::OP_REVERSE, 8'h00, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_READ,    8'h00, 7'd1));
      directed.push_back(make_req(bswr_pkg::OP_PUSH,    8'hFF, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_PUSH,    8'hA5, 7'd64));
      directed.push_back(make_req(bswr_pkg::OP_PEEK,    8'h00, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_READ,    8'h00, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_READ,    8'h00, 7'd3));
      directed.push_back(make_req(bswr_pkg::OP_READ,    8'h00, 7'd4));
      directed.push_back(make_req(bswr_pkg::OP_READ,    8'h00, 7'd127));
      directed.push_back(make_req(bswr_pkg::OP_REVERSE, 8'h5A, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_READ,    8'h00, 7'd1));
      directed.push_back(make_req(bswr_pkg::OP_POP,     8'h00, 7'd0));
      directed.push_back(make_req(OP_SPARE_6,           8'hFF, 7'd127));
      directed.push_back(make_req(OP_SPARE_7,           8'hFF, 7'd127));
      directed.push_back(make_req(bswr_pkg::OP_CLEAR,   8'h00, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_POP,     8'h00, 7'd0));
      directed.push_back(make_req(bswr_pkg::OP_PEEK,    8'h00, 7'd0));
      foreach (directed[i]) send_request(directed[i]);

      // Random part in phases with different operation mixes and idle behavior.
      phase_left = 0;
      repeat (RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            phase_left   = $urandom_range(60, 150);
            mix          = mix_type'($urandom_range(0, 3));
            no_gap_phase = ($urandom_range(0, 3) == 0);
         end
         phase_left--;
         send_request(random_req());
      end
      @(negedge clock);
      start <= 1'b0;

      // Drain: wait for outstanding responses, then watch for stray strobes.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses; deepest stack %0d,",
               sent, sb.checked, sb.deepest);
      $display("%0d reverses of two or more elements.", sb.wide_reverses);
      $display("Statuses seen: ok %0d, overflow %0d, underflow %0d, out of range %0d.",
               sb.status_seen[bswr_pkg::ST_OK], sb.status_seen[bswr_pkg::ST_OVERFLOW],
               sb.status_seen[bswr_pkg::ST_UNDERFLOW], sb.status_seen[bswr_pkg::ST_RANGE]);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
